// ===== rtl/pwbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pwbd_pkg
// Shared types and constants of the pulse-width bit decoder: transaction
// payloads, action and status codes, configuration register indexes.
// ----------------------------------------------------------------------------
package pwbd_pkg;

    // Clamp limits for the byte count and skip count registers
    localparam int MAX_BYTES = 16;
    localparam int MAX_SKIP  = 15;

    // Bits per data byte and position of the last bit in a byte
    localparam int BYTE_BITS = 8;
    localparam logic [2:0] LAST_BIT_POS = 3'd7;

    // Saturation value of the pulse counter
    localparam logic [7:0] PULSE_MAX = 8'hFF;

    // Configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        ACT_RELEASE = 2'd0,
        ACT_EDGE    = 2'd1,
        ACT_TIMEOUT = 2'd2,
        ACT_UNUSED  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_MID_READ = 2'd0,
        ST_FULL     = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_LOW   = 3'd0,
        CFG_HIGH_ZERO    = 3'd1,
        CFG_HIGH_ONE     = 3'd2,
        CFG_SKIP_BITS    = 3'd3,
        CFG_BYTE_COUNT   = 3'd4,
        CFG_READ_TIMEOUT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] timestamp_us;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] byte_index;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    // Current register values as seen by the datapath
    typedef struct packed {
        logic [15:0] period_low_us;
        logic [15:0] high_zero_us;
        logic [15:0] high_one_us;
        logic [3:0]  skip_bits;
        logic [4:0]  byte_count;
        logic [23:0] read_timeout_us;
    } t_cfg;

    // Magnitude of a wrapped 32-bit signed difference
    function automatic logic [31:0] mag32(input logic [31:0] d);
        mag32 = d[31] ? (32'd0 - d) : d;
    endfunction

endpackage

// ===== rtl/pwbd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pwbd_cfg_regs
// Configuration register file. Writes to indexes beyond the list are dropped.
// ----------------------------------------------------------------------------
module pwbd_cfg_regs
    import pwbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes, reset to the power-on defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_low_us   <= 16'd50;
            r_cfg.high_zero_us    <= 16'd26;
            r_cfg.high_one_us     <= 16'd70;
            r_cfg.skip_bits       <= 4'd1;
            r_cfg.byte_count      <= 5'd5;
            r_cfg.read_timeout_us <= 24'd10000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PERIOD_LOW:   r_cfg.period_low_us   <= i_cfg_data[15:0];
                CFG_HIGH_ZERO:    r_cfg.high_zero_us    <= i_cfg_data[15:0];
                CFG_HIGH_ONE:     r_cfg.high_one_us     <= i_cfg_data[15:0];
                CFG_SKIP_BITS:    r_cfg.skip_bits       <= i_cfg_data[3:0];
                CFG_BYTE_COUNT:   r_cfg.byte_count      <= i_cfg_data[4:0];
                CFG_READ_TIMEOUT: r_cfg.read_timeout_us <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/pwbd_step.sv =====
// ----------------------------------------------------------------------------
// pwbd_step
// Read state and per-event decode: measures the pulse, picks the nearer high
// time, packs bits MSB first and builds the byte or timeout result.
// ----------------------------------------------------------------------------
module pwbd_step
    import pwbd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output logic      o_has_result,
    output t_out_item o_result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READING,
        PH_DONE
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [31:0] r_start,  n_start;
    logic [31:0] r_last,   n_last;
    logic [7:0]  r_pulses, n_pulses;
    logic [7:0]  r_partial, n_partial;
    logic [4:0]  r_byte_no, n_byte_no;

    logic [3:0]  eff_skip;
    logic [4:0]  eff_count;
    logic [31:0] interval, high_time, dist_zero, dist_one, elapsed;
    logic        bit_val;
    logic [7:0]  data_pos;
    logic [2:0]  nbits;
    logic [7:0]  shifted;
    logic [5:0]  next_byte;

    // Clamped register values
    always_comb begin
        eff_skip = (int'(i_cfg.skip_bits) > MAX_SKIP) ? 4'(MAX_SKIP) : i_cfg.skip_bits;
        if (i_cfg.byte_count == 5'd0)
            eff_count = 5'd1;
        else if (int'(i_cfg.byte_count) > MAX_BYTES)
            eff_count = 5'(MAX_BYTES);
        else
            eff_count = i_cfg.byte_count;
    end

    // Pulse measurement and bit decision; ties give zero
    assign interval  = i_item.timestamp_us - r_last;
    assign high_time = interval - {16'd0, i_cfg.period_low_us};
    assign dist_zero = mag32(high_time - {16'd0, i_cfg.high_zero_us});
    assign dist_one  = mag32(high_time - {16'd0, i_cfg.high_one_us});
    assign bit_val   = dist_one < dist_zero;

    assign data_pos  = r_pulses - {4'd0, eff_skip};
    assign elapsed   = i_item.timestamp_us - r_start;
    assign next_byte = {1'b0, r_byte_no} + 6'd1;

    // Partial byte left-aligned for a timeout, missing low bits zero
    always_comb begin
        nbits   = (r_pulses >= {4'd0, eff_skip}) ? data_pos[2:0] : 3'd0;
        shifted = (nbits == 3'd0) ? 8'd0
                                  : 8'(r_partial << (4'(BYTE_BITS) - {1'b0, nbits}));
    end

    // Next state and result
    always_comb begin
        n_phase      = r_phase;
        n_start      = r_start;
        n_last       = r_last;
        n_pulses     = r_pulses;
        n_partial    = r_partial;
        n_byte_no    = r_byte_no;
        o_has_result = 1'b0;
        o_result     = '0;
        if (i_item.action == ACT_RELEASE) begin
            n_phase   = PH_READING;
            n_start   = i_item.timestamp_us;
            n_last    = i_item.timestamp_us;
            n_pulses  = 8'd0;
            n_partial = 8'd0;
            n_byte_no = 5'd0;
        end else if (r_phase == PH_READING && i_item.action == ACT_EDGE) begin
            n_last = i_item.timestamp_us;
            if (r_pulses != PULSE_MAX)
                n_pulses = r_pulses + 8'd1;
            if (r_pulses >= {4'd0, eff_skip}) begin
                n_partial = {r_partial[6:0], bit_val};
                if (data_pos[2:0] == LAST_BIT_POS) begin
                    o_has_result        = 1'b1;
                    o_result.data_byte  = {r_partial[6:0], bit_val};
                    o_result.byte_index = r_byte_no[3:0];
                    n_partial           = 8'd0;
                    n_byte_no           = next_byte[4:0];
                    if (next_byte >= {1'b0, eff_count}) begin
                        n_phase         = PH_DONE;
                        o_result.status = ST_FULL;
                        o_result.last   = 1'b1;
                    end else begin
                        o_result.status = ST_MID_READ;
                        o_result.last   = 1'b0;
                    end
                end
            end
        end else if (r_phase == PH_READING && i_item.action == ACT_TIMEOUT) begin
            if (elapsed >= {8'd0, i_cfg.read_timeout_us}) begin
                n_phase             = PH_DONE;
                o_has_result        = 1'b1;
                o_result.data_byte  = shifted;
                o_result.byte_index = r_byte_no[3:0];
                o_result.status     = ST_TIMEOUT;
                o_result.last       = 1'b1;
            end
        end
    end

    // State registers, updated once per processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_start   <= '0;
            r_last    <= '0;
            r_pulses  <= '0;
            r_partial <= '0;
            r_byte_no <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_start   <= n_start;
            r_last    <= n_last;
            r_pulses  <= n_pulses;
            r_partial <= n_partial;
            r_byte_no <= n_byte_no;
        end
    end

endmodule

// ===== rtl/pulse_width_bit_decoder_core.sv =====
// Datapath: an accepted input transaction is held in the input register, and
// its result is then stored in the result register.
// Throughput: one input transaction per cycle; an event is held only while
// it produces a result and the result register is still occupied.
// Reset: synchronous active-low; registers return to defaults, read is idle.
// ----------------------------------------------------------------------------
// pulse_width_bit_decoder_core
// Single-wire pulse-width bit decoder: timestamped events in, bytes out.
// ----------------------------------------------------------------------------
module pulse_width_bit_decoder_core
    import pwbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      w_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_has_result;
    t_out_item w_result;
    logic      w_fire;

    pwbd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pwbd_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_item       (r_in_item),
        .i_cfg        (w_cfg),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    // Process the held event unless its result would overwrite a pending one
    assign w_fire     = r_in_valid && (!w_has_result || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_has_result) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

// ===== rtl/pwbd_core_checker.sv =====
// ----------------------------------------------------------------------------
// pwbd_core_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pwbd_core_checker
    import pwbd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_data
);

    // A stalled result transaction keeps its valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result transaction changed while stalled");

    // Nothing is shown the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Full and timeout results close the read; mid-read bytes do not
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == (o_out_data.status != ST_MID_READ)))
        else $error("last flag disagrees with status");

    // Only defined status codes are shown
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_MID_READ ||
                         o_out_data.status == ST_FULL ||
                         o_out_data.status == ST_TIMEOUT))
        else $error("undefined status code");

endmodule

bind pulse_width_bit_decoder_core pwbd_core_checker u_pwbd_core_checker (.*);
